// File: rtl/tagged_value_stream_decoder_top_assert.svh
// Assertion macros for the tagged value stream decoder checker
`ifndef TAGGED_VALUE_STREAM_DECODER_TOP_ASSERT_SVH
`define TAGGED_VALUE_STREAM_DECODER_TOP_ASSERT_SVH

// Check a consequent in the same cycle
`define TVSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tvsd check failed");

// Check a consequent in the next cycle
`define TVSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tvsd check failed");

`endif

// File: rtl/tvsd_pkg.sv
// Types, codes and helper functions shared by the decoder modules
`default_nettype none
package tvsd_pkg;
    localparam int MAX_LEVELS = 32;
    localparam int LVL_W = $clog2(MAX_LEVELS + 1);
    localparam int IDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    localparam logic [3:0] K_NIL      = 4'd0;
    localparam logic [3:0] K_BOOL     = 4'd1;
    localparam logic [3:0] K_INT      = 4'd2;
    localparam logic [3:0] K_REAL     = 4'd3;
    localparam logic [3:0] K_STR      = 4'd4;
    localparam logic [3:0] K_STR_BYTE = 4'd5;
    localparam logic [3:0] K_TBL      = 4'd6;
    localparam logic [3:0] K_TBL_END  = 4'd7;
    localparam logic [3:0] K_ERR      = 4'd8;

    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_TRUNC     = 3'd1;
    localparam logic [2:0] E_INT_CK    = 3'd2;
    localparam logic [2:0] E_LSTR_CK   = 3'd3;
    localparam logic [2:0] E_TYPE      = 3'd4;
    localparam logic [2:0] E_CNT_HDR   = 3'd5;
    localparam logic [2:0] E_TOO_DEEP  = 3'd6;

    localparam logic [2:0] T_NIL   = 3'd0;
    localparam logic [2:0] T_BOOL  = 3'd1;
    localparam logic [2:0] T_NUM   = 3'd2;
    localparam logic [2:0] T_SSTR  = 3'd4;
    localparam logic [2:0] T_LSTR  = 3'd5;
    localparam logic [2:0] T_TABLE = 3'd6;

    localparam logic [1:0] SLOT_ARRAY = 2'd0;
    localparam logic [1:0] SLOT_KEY   = 2'd1;
    localparam logic [1:0] SLOT_VALUE = 2'd2;

    localparam logic [4:0] CK_ZERO = 5'd0;
    localparam logic [4:0] CK_U8   = 5'd1;
    localparam logic [4:0] CK_U16  = 5'd2;
    localparam logic [4:0] CK_S32  = 5'd4;
    localparam logic [4:0] CK_S64  = 5'd6;
    localparam logic [4:0] CK_REAL = 5'd8;
    localparam logic [4:0] CK_ESC  = 5'd31;

    typedef enum logic [5:0] {
        PH_TAG     = 6'b000001,
        PH_INT     = 6'b000010,
        PH_REAL    = 6'b000100,
        PH_STRLEN  = 6'b001000,
        PH_STR     = 6'b010000,
        PH_CNT_TAG = 6'b100000,
        PH_CNT_INT = 6'b000000
    } t_phase;

    typedef struct packed {
        logic [1:0]  slot;
        logic [31:0] cnt;
    } t_lvl;

    typedef struct packed {
        logic [3:0]       kind;
        logic [63:0]      value;
        logic             is_key;
        logic [LVL_W-1:0] level;
        logic [2:0]       err;
        logic             str_end;
        logic             pkt_end;
        logic             last;
    } t_res;

    typedef struct packed {
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
    } t_emit;

    function automatic t_lvl lvl_advance(input t_lvl e);
        t_lvl o;
        o = e;
        case (e.slot)
            SLOT_ARRAY: begin
                if (e.cnt != 32'd0) o.cnt = e.cnt - 32'd1;
                o.slot = (o.cnt == 32'd0) ? SLOT_KEY : SLOT_ARRAY;
            end
            SLOT_KEY: o.slot = SLOT_VALUE;
            default: o.slot = SLOT_KEY;
        endcase
        return o;
    endfunction

    function automatic logic [31:0] int_len(input logic [4:0] ck);
        logic [31:0] n;
        case (ck)
            CK_U8:   n = 32'd1;
            CK_U16:  n = 32'd2;
            CK_S32:  n = 32'd4;
            default: n = 32'd8;
        endcase
        return n;
    endfunction

    function automatic logic int_ck_ok(input logic [4:0] ck);
        return (ck == CK_U8) || (ck == CK_U16) || (ck == CK_S32) || (ck == CK_S64);
    endfunction

    function automatic logic [63:0] int_value(input logic [63:0] acc, input logic [4:0] ck);
        logic [63:0] v;
        v = acc;
        if (ck == CK_S32) v = {{32{acc[31]}}, acc[31:0]};
        return v;
    endfunction
endpackage
`default_nettype wire

// File: rtl/tagged_value_stream_decoder_top.sv
// Top level of the tagged value stream decoder
// An accepted byte's token words pass through the registered output queue.
// Throughput: one byte per cycle while m_axis_tready is high and each byte yields at
// most one word; a byte that also ends a packet early yields two, drained one a cycle.
// s_axis_tready drops when the four-word output queue cannot take two more words.
// Reset (i_rst_n low, synchronous) returns the parser to tag phase at top level
// and sets depth_limit to 32; stack entries are not cleared.
`default_nettype none
module tagged_value_stream_decoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [5:0]  i_cfg_wdata,   // depth_limit
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // in_byte
    input  wire logic        s_axis_tlast,  // in_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [63:0] token_value, [64] is_key, [70:65] nest_level, [73:71] error_code,
    // [74] string_end, [75] last_result, [79:76] zero
    output logic [79:0]      m_axis_tdata,
    output logic [3:0]       m_axis_tuser,  // token_kind
    output logic             m_axis_tlast   // packet_end
);
    logic [5:0]      r_depth_limit;
    logic            accept;
    tvsd_pkg::t_emit emit;
    tvsd_pkg::t_res  res;

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_limit <= 6'd32;
        end else if (i_cfg_we) begin
            r_depth_limit <= i_cfg_wdata;
        end
    end

    tvsd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_byte        (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .i_depth_limit (r_depth_limit),
        .o_emit        (emit)
    );

    tvsd_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .o_room  (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = {4'd0, res.last, res.str_end, res.err, res.level,
                           res.is_key, res.value};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.pkt_end;
endmodule
`default_nettype wire

// File: rtl/tvsd_parser.sv
// Byte parser: phase state, field accumulator and level stack
`default_nettype none
module tvsd_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_last,
    input  wire logic [5:0]      i_depth_limit,
    output tvsd_pkg::t_emit      o_emit
);
    tvsd_pkg::t_phase                 r_phase, n_phase;
    logic [63:0]                      r_acc, n_acc;
    logic [31:0]                      r_rem, n_rem;
    logic [4:0]                       r_ck, n_ck;
    logic [2:0]                       r_pos, n_pos;
    logic [tvsd_pkg::LVL_W-1:0]       r_ptr, n_ptr;
    logic                             r_disc, n_disc;
    tvsd_pkg::t_lvl                   r_top, n_top;
    tvsd_pkg::t_lvl                   r_stk [tvsd_pkg::MAX_LEVELS];

    logic [tvsd_pkg::LVL_W-1:0] ptr_m1, ptr_m2, limit;
    logic [2:0]  typ;
    logic [4:0]  ck;
    logic        cur_key, emit0, err, do_vd, pop, push, trunc, clr;
    logic [63:0] acc_m, ival;
    logic [31:0] rem_dec, cnt_new, opn_cnt;
    tvsd_pkg::t_res res0, res1;
    tvsd_pkg::t_lvl parent;

    assign ptr_m1 = r_ptr - 1'b1;
    assign ptr_m2 = r_ptr - 2'd2;
    assign typ = i_byte[2:0];
    assign ck = i_byte[7:3];
    assign cur_key = (r_ptr != '0) && (r_top.slot == tvsd_pkg::SLOT_KEY);
    assign acc_m = r_acc | ({56'd0, i_byte} << {r_pos, 3'b000});
    assign rem_dec = (r_rem != 32'd0) ? r_rem - 32'd1 : r_rem;
    assign ival = tvsd_pkg::int_value(acc_m, r_ck);
    assign parent = r_stk[ptr_m2[tvsd_pkg::IDX_W-1:0]];
    assign limit = (i_depth_limit < 6'(tvsd_pkg::MAX_LEVELS)) ?
                   tvsd_pkg::LVL_W'(i_depth_limit) : tvsd_pkg::LVL_W'(tvsd_pkg::MAX_LEVELS);

    always_comb begin
        n_phase = r_phase;
        n_acc = r_acc;
        n_rem = r_rem;
        n_ck = r_ck;
        n_pos = r_pos;
        n_ptr = r_ptr;
        n_disc = r_disc;
        n_top = r_top;
        emit0 = 1'b0;
        err = 1'b0;
        do_vd = 1'b0;
        pop = 1'b0;
        push = 1'b0;
        opn_cnt = 32'd0;
        cnt_new = 32'd0;
        res0 = '0;
        res0.is_key = cur_key;
        res0.level = r_ptr;

        if (!r_disc) begin
            case (r_phase)
                tvsd_pkg::PH_TAG: begin
                    case (typ)
                        tvsd_pkg::T_NIL: begin
                            emit0 = 1'b1;
                            do_vd = 1'b1;
                            if (cur_key) begin
                                res0.kind = tvsd_pkg::K_TBL_END;
                                res0.is_key = 1'b0;
                                res0.level = ptr_m1;
                                pop = 1'b1;
                            end else begin
                                res0.kind = tvsd_pkg::K_NIL;
                            end
                        end
                        tvsd_pkg::T_BOOL: begin
                            emit0 = 1'b1;
                            do_vd = 1'b1;
                            res0.kind = tvsd_pkg::K_BOOL;
                            res0.value = {63'd0, ck != 5'd0};
                        end
                        tvsd_pkg::T_NUM: begin
                            if (ck == tvsd_pkg::CK_REAL) begin
                                n_phase = tvsd_pkg::PH_REAL;
                                n_ck = ck; n_acc = '0; n_pos = '0; n_rem = 32'd8;
                            end else if (ck == tvsd_pkg::CK_ZERO) begin
                                emit0 = 1'b1;
                                do_vd = 1'b1;
                                res0.kind = tvsd_pkg::K_INT;
                            end else if (tvsd_pkg::int_ck_ok(ck)) begin
                                n_phase = tvsd_pkg::PH_INT;
                                n_ck = ck; n_acc = '0; n_pos = '0;
                                n_rem = tvsd_pkg::int_len(ck);
                            end else begin
                                err = 1'b1;
                                res0.err = tvsd_pkg::E_INT_CK;
                            end
                        end
                        tvsd_pkg::T_SSTR: begin
                            emit0 = 1'b1;
                            res0.kind = tvsd_pkg::K_STR;
                            res0.value = {59'd0, ck};
                            if (ck == 5'd0) begin
                                res0.str_end = 1'b1;
                                do_vd = 1'b1;
                            end else begin
                                n_phase = tvsd_pkg::PH_STR;
                                n_rem = {27'd0, ck};
                            end
                        end
                        tvsd_pkg::T_LSTR: begin
                            if (ck == tvsd_pkg::CK_U16 || ck == tvsd_pkg::CK_S32) begin
                                n_phase = tvsd_pkg::PH_STRLEN;
                                n_ck = ck; n_acc = '0; n_pos = '0;
                                n_rem = (ck == tvsd_pkg::CK_U16) ? 32'd2 : 32'd4;
                            end else begin
                                err = 1'b1;
                                res0.err = tvsd_pkg::E_LSTR_CK;
                            end
                        end
                        tvsd_pkg::T_TABLE: begin
                            if (r_ptr >= limit) begin
                                err = 1'b1;
                                res0.err = tvsd_pkg::E_TOO_DEEP;
                            end else if (ck == tvsd_pkg::CK_ESC) begin
                                n_phase = tvsd_pkg::PH_CNT_TAG;
                            end else begin
                                push = 1'b1;
                                opn_cnt = {27'd0, ck};
                            end
                        end
                        default: begin
                            err = 1'b1;
                            res0.err = tvsd_pkg::E_TYPE;
                        end
                    endcase
                end
                tvsd_pkg::PH_CNT_TAG: begin
                    if (typ != tvsd_pkg::T_NUM || ck == tvsd_pkg::CK_REAL) begin
                        err = 1'b1;
                        res0.err = tvsd_pkg::E_CNT_HDR;
                    end else if (ck == tvsd_pkg::CK_ZERO) begin
                        push = 1'b1;
                    end else if (tvsd_pkg::int_ck_ok(ck)) begin
                        n_phase = tvsd_pkg::PH_CNT_INT;
                        n_ck = ck; n_acc = '0; n_pos = '0;
                        n_rem = tvsd_pkg::int_len(ck);
                    end else begin
                        err = 1'b1;
                        res0.err = tvsd_pkg::E_INT_CK;
                    end
                end
                tvsd_pkg::PH_STR: begin
                    emit0 = 1'b1;
                    n_rem = rem_dec;
                    res0.kind = tvsd_pkg::K_STR_BYTE;
                    res0.value = {56'd0, i_byte};
                    res0.is_key = 1'b0;
                    res0.str_end = (rem_dec == 32'd0);
                    if (rem_dec == 32'd0) begin
                        n_phase = tvsd_pkg::PH_TAG;
                        do_vd = 1'b1;
                    end
                end
                tvsd_pkg::PH_INT, tvsd_pkg::PH_REAL, tvsd_pkg::PH_STRLEN,
                tvsd_pkg::PH_CNT_INT: begin
                    n_acc = acc_m;
                    n_pos = r_pos + 3'd1;
                    n_rem = rem_dec;
                    if (rem_dec == 32'd0) begin
                        n_phase = tvsd_pkg::PH_TAG;
                        case (r_phase)
                            tvsd_pkg::PH_INT: begin
                                emit0 = 1'b1; do_vd = 1'b1;
                                res0.kind = tvsd_pkg::K_INT;
                                res0.value = ival;
                            end
                            tvsd_pkg::PH_REAL: begin
                                emit0 = 1'b1; do_vd = 1'b1;
                                res0.kind = tvsd_pkg::K_REAL;
                                res0.value = acc_m;
                            end
                            tvsd_pkg::PH_STRLEN: begin
                                emit0 = 1'b1;
                                res0.kind = tvsd_pkg::K_STR;
                                res0.value = {32'd0, acc_m[31:0]};
                                res0.str_end = (acc_m[31:0] == 32'd0);
                                if (acc_m[31:0] == 32'd0) begin
                                    do_vd = 1'b1;
                                end else begin
                                    n_phase = tvsd_pkg::PH_STR;
                                    n_rem = acc_m[31:0];
                                end
                            end
                            default: begin
                                push = 1'b1;
                                opn_cnt = ival[31] ? 32'd0 : ival[31:0];
                            end
                        endcase
                    end
                end
                default: n_phase = tvsd_pkg::PH_TAG;
            endcase

            if (push) begin
                emit0 = 1'b1;
                res0.kind = tvsd_pkg::K_TBL;
                res0.value = {32'd0, opn_cnt};
                n_phase = tvsd_pkg::PH_TAG;
                n_ptr = r_ptr + 1'b1;
                n_top.cnt = opn_cnt;
                n_top.slot = (opn_cnt != 32'd0) ? tvsd_pkg::SLOT_ARRAY : tvsd_pkg::SLOT_KEY;
            end else if (pop) begin
                n_ptr = ptr_m1;
                n_top = tvsd_pkg::lvl_advance(parent);
            end else if (do_vd && r_ptr != '0) begin
                n_top = tvsd_pkg::lvl_advance(r_top);
            end
            if (err) begin
                emit0 = 1'b1;
                res0.kind = tvsd_pkg::K_ERR;
                res0.value = '0;
                res0.is_key = 1'b0;
                res0.level = r_ptr;
                n_disc = 1'b1;
            end
        end

        trunc = !r_disc && !err && i_last && (n_phase != tvsd_pkg::PH_TAG || n_ptr != '0);
        res1 = '0;
        res1.kind = tvsd_pkg::K_ERR;
        res1.level = n_ptr;
        res1.err = tvsd_pkg::E_TRUNC;
        res1.pkt_end = 1'b1;
        res1.last = 1'b1;

        clr = i_last;
        if (clr) begin
            n_phase = tvsd_pkg::PH_TAG;
            n_acc = '0; n_rem = '0; n_ck = '0; n_pos = '0;
            n_ptr = '0; n_disc = 1'b0;
        end

        o_emit = '0;
        if (emit0) begin
            o_emit.r0 = res0;
            o_emit.r0.last = !trunc;
            o_emit.r0.pkt_end = i_last && !trunc;
            o_emit.r1 = res1;
            o_emit.cnt = trunc ? 2'd2 : 2'd1;
        end else if (trunc) begin
            o_emit.r0 = res1;
            o_emit.cnt = 2'd1;
        end
        if (!i_accept) o_emit.cnt = 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tvsd_pkg::PH_TAG;
            r_acc <= '0;
            r_rem <= '0;
            r_ck <= '0;
            r_pos <= '0;
            r_ptr <= '0;
            r_disc <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_acc <= n_acc;
            r_rem <= n_rem;
            r_ck <= n_ck;
            r_pos <= n_pos;
            r_ptr <= n_ptr;
            r_disc <= n_disc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_top <= n_top;
            if (push && !r_disc && r_ptr != '0) begin
                r_stk[ptr_m1[tvsd_pkg::IDX_W-1:0]] <= r_top;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/tvsd_out_queue.sv
// Four-word result queue taking up to two words per cycle
`default_nettype none
module tvsd_out_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  tvsd_pkg::t_emit     i_emit,
    output logic                o_room,
    output logic                o_valid,
    input  wire logic           i_ready,
    output tvsd_pkg::t_res      o_res
);
    tvsd_pkg::t_res r_mem [4];
    logic [1:0] r_wr, r_rd, n_wr, n_rd;
    logic [2:0] r_cnt, n_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 3'd0);
    assign o_room = (r_cnt <= 3'd2);
    assign o_res = r_mem[r_rd];
    assign pop = o_valid && i_ready;

    always_comb begin
        n_wr = r_wr + i_emit.cnt;
        n_rd = r_rd + {1'b0, pop};
        n_cnt = r_cnt + {1'b0, i_emit.cnt} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.cnt != 2'd0) r_mem[r_wr] <= i_emit.r0;
        if (i_emit.cnt == 2'd2) r_mem[r_wr + 2'd1] <= i_emit.r1;
    end
endmodule
`default_nettype wire

// File: rtl/tvsd_checker.sv
// Port-level checker for the decoder and its bind to the top level
`default_nettype none
`include "tagged_value_stream_decoder_top_assert.svh"
module tvsd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [79:0] m_axis_tdata,
    input wire logic [3:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);
    `TVSD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `TVSD_ASSERT_NOW(a_pkt_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata[75])
    `TVSD_ASSERT_NOW(a_err_code, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != tvsd_pkg::K_ERR, m_axis_tdata[73:71] == tvsd_pkg::E_NONE)
    `TVSD_ASSERT_NOW(a_err_val, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == tvsd_pkg::K_ERR, m_axis_tdata[63:0] == 64'd0 && m_axis_tdata[73:71] != tvsd_pkg::E_NONE)
endmodule

bind tagged_value_stream_decoder_top tvsd_checker u_tvsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
